@@ design/sdiv_pkg.sv @@
`timescale 1ns / 1ps

package sdiv_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FIELD_W    = 32;
    localparam int CNT_W      = $clog2(DATA_WIDTH + 1);

    localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FIX
    } t_state;

    typedef struct packed {
        logic                  start;
        logic [DATA_WIDTH-1:0] dividend;
        logic [DATA_WIDTH-1:0] divisor;
    } t_div_ctrl;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [DATA_WIDTH-1:0] quotient;
    } t_div_stat;

    // most negative value maps onto itself, read as unsigned it is the right magnitude
    function automatic logic [DATA_WIDTH-1:0] magnitude(input logic [DATA_WIDTH-1:0] v);
        magnitude = v[DATA_WIDTH-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

@@ design/sdiv_core.sv @@
`timescale 1ns / 1ps

// unsigned restoring divider, one quotient bit per cycle
module sdiv_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sdiv_pkg::t_div_ctrl i_ctrl,
    output sdiv_pkg::t_div_stat o_stat
);

    localparam int DW = sdiv_pkg::DATA_WIDTH;

    logic                         r_busy, n_busy;
    logic                         r_done, n_done;
    logic [sdiv_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic [DW-1:0]                r_q, n_q;
    logic [DW-1:0]                r_rem, n_rem;
    logic [DW-1:0]                r_d, n_d;
    logic [DW:0]                  rem_sh;
    logic [DW:0]                  diff;

    always_comb begin
        rem_sh = {r_rem, r_q[DW-1]};
        diff   = rem_sh - {1'b0, r_d};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_d    = r_d;
        if (i_ctrl.start) begin
            n_busy = 1'b1;
            n_cnt  = sdiv_pkg::CNT_W'(DW);
            n_q    = i_ctrl.dividend;
            n_rem  = '0;
            n_d    = i_ctrl.divisor;
        end else if (r_busy) begin
            // no borrow: subtract and take a one
            if (!diff[DW]) begin
                n_rem = diff[DW-1:0];
            end else begin
                n_rem = rem_sh[DW-1:0];
            end
            n_q   = {r_q[DW-2:0], ~diff[DW]};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == sdiv_pkg::CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_rem <= n_rem;
        r_d   <= n_d;
    end

    assign o_stat.busy     = r_busy;
    assign o_stat.done     = r_done;
    assign o_stat.quotient = r_q;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.start |-> !r_busy)
        else $error("divider started while busy");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == sdiv_pkg::CNT_W'(1) && !i_ctrl.start) |=> r_done)
        else $error("last step did not raise done");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("done with divider still busy");

endmodule

@@ design/signed_divider_saturating_unit.sv @@
`timescale 1ns / 1ps

// channel | direction | handshake                   | words
// in      | input     | i_in_valid / o_in_ready     | i_numerator, i_denominator
// out     | output    | o_out_valid / i_out_ready   | o_quotient
//
// After a word is taken the divider forms its quotient bit by bit; the sequencer then
// sees the divider's done flag in S_DIV and does the sign fix and saturation in S_FIX.
// Input is ready again only back in S_IDLE, so a new word waits until S_FIX is left.
// Reset clears the sequencer, the divider control and the output valid.
// A result waiting at the output does not block the next word; the finished
// quotient waits in the fixup state only if the output register is still full.
module signed_divider_saturating_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [sdiv_pkg::FIELD_W-1:0] i_numerator,
    input  logic signed [sdiv_pkg::FIELD_W-1:0] i_denominator,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [sdiv_pkg::FIELD_W-1:0] o_quotient
);

    localparam int DW = sdiv_pkg::DATA_WIDTH;

    sdiv_pkg::t_state    r_state, n_state;
    sdiv_pkg::t_div_ctrl ctrl;
    sdiv_pkg::t_div_stat stat;

    logic          r_nn, n_nn;
    logic          r_dn, n_dn;
    logic          r_zero, n_zero;
    logic          r_out_valid, n_out_valid;
    logic [DW-1:0] r_out_q, n_out_q;
    logic          in_acc;
    logic          load_out;
    logic          neg;
    logic          sat;
    logic [DW-1:0] fixed_q;
    logic [DW-1:0] num_w;
    logic [DW-1:0] den_w;

    assign num_w  = i_numerator[DW-1:0];
    assign den_w  = i_denominator[DW-1:0];
    assign in_acc = i_in_valid && o_in_ready;

    assign ctrl.start    = in_acc;
    assign ctrl.dividend = sdiv_pkg::magnitude(num_w);
    assign ctrl.divisor  = sdiv_pkg::magnitude(den_w);

    sdiv_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .o_stat  (stat)
    );

    always_comb begin
        neg = (r_nn != r_dn) && (stat.quotient != '0);
        // zero divisor, or min over minus one
        sat = r_zero || (!neg && (stat.quotient > sdiv_pkg::MAX_POS));
        if (sat) begin
            fixed_q = sdiv_pkg::MAX_POS;
        end else if (neg) begin
            fixed_q = ~stat.quotient + 1'b1;
        end else begin
            fixed_q = stat.quotient;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_nn       = r_nn;
        n_dn       = r_dn;
        n_zero     = r_zero;
        o_in_ready = 1'b0;
        load_out   = 1'b0;
        case (r_state)
            sdiv_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_nn    = num_w[DW-1];
                    n_dn    = den_w[DW-1];
                    n_zero  = (den_w == '0);
                    n_state = sdiv_pkg::S_DIV;
                end
            end
            sdiv_pkg::S_DIV: begin
                if (stat.done) begin
                    n_state = sdiv_pkg::S_FIX;
                end
            end
            sdiv_pkg::S_FIX: begin
                if (!r_out_valid || i_out_ready) begin
                    load_out = 1'b1;
                    n_state  = sdiv_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sdiv_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_q = r_out_q;
        if (load_out) begin
            n_out_valid = 1'b1;
            n_out_q     = fixed_q;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sdiv_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nn    <= n_nn;
        r_dn    <= n_dn;
        r_zero  <= n_zero;
        r_out_q <= n_out_q;
    end

    assign o_out_valid = r_out_valid;
    assign o_quotient  = sdiv_pkg::FIELD_W'(r_out_q);

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == sdiv_pkg::S_DIV && stat.busy))
        else $error("accepted word did not start the divider");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.done |-> r_state == sdiv_pkg::S_DIV)
        else $error("divider finished outside the divide state");

    a_fix_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sdiv_pkg::S_FIX && !r_out_valid) |=>
        (r_out_valid && r_state == sdiv_pkg::S_IDLE))
        else $error("fixup did not load an empty output register");

endmodule
